/* hdl/fkv_pkg.sv */
// shared types, character codes and key tables of the framed key/value command parser
`timescale 1ns / 1ps
`default_nettype none

package fkv_pkg;

   localparam int NUM_KEYS = 6;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_OPEN    = 8'h3c;  // <
   localparam logic [7:0] CHAR_CLOSE   = 8'h3e;  // >
   localparam logic [7:0] CHAR_COLON   = 8'h3a;  // :
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   localparam logic [2:0] MSG_ERROR = 3'd0;
   localparam logic [2:0] MSG_PING  = 3'd1;

   localparam logic [1:0] ERR_NOT_FRAMED  = 2'd0;
   localparam logic [1:0] ERR_NO_COLON    = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN_KEY = 2'd2;

   localparam logic [2:0] KEY_PING = 3'd0;

   typedef enum logic [1:0] {
      LINE_START = 2'd0,
      LINE_KEY   = 2'd1,
      LINE_VALUE = 2'd2
   } line_phase_type;

   typedef enum logic [1:0] {
      NUM_SPACE  = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2,
      NUM_DONE   = 2'd3
   } num_phase_type;

   typedef enum logic [2:0] {
      TRUE_0    = 3'd0,
      TRUE_1    = 3'd1,
      TRUE_2    = 3'd2,
      TRUE_3    = 3'd3,
      TRUE_4    = 3'd4,
      TRUE_HIT  = 3'd5,
      TRUE_MISS = 3'd6
   } true_match_type;

   // per-beat strobes from the line controller to the key and value trackers
   typedef struct packed {
      logic line_end;
      logic key_en;
      logic value_en;
   } fkv_step_type;

   typedef struct packed {
      logic [2:0]  msg_type;
      logic [1:0]  error_code;
      logic        ping_flag;
      logic [31:0] motor_value;
   } fkv_result_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [3:0] key_len(input logic [2:0] key);
      return (key == KEY_PING) ? 4'd4 : 4'd7;
   endfunction

   // PING, then MOTOR_0 .. MOTOR_4
   function automatic logic [7:0] key_char(input logic [2:0] key, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (key == KEY_PING) begin
         case (pos)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h4e;
            3'd3:    c = 8'h47;
            default: c = 8'h00;
         endcase
      end else begin
         case (pos)
            3'd0:    c = 8'h4d;
            3'd1:    c = 8'h4f;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h4f;
            3'd4:    c = 8'h52;
            3'd5:    c = 8'h5f;
            3'd6:    c = CHAR_ZERO + {5'd0, key - 3'd1};
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   // lower-case letters of "true"
   function automatic logic [7:0] true_char(input true_match_type st);
      logic [7:0] c;
      case (st)
         TRUE_0:  c = 8'h74;
         TRUE_1:  c = 8'h72;
         TRUE_2:  c = 8'h75;
         TRUE_3:  c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/fkv_key_match.sv */
// case-insensitive key matcher against the known command keys
`timescale 1ns / 1ps
`default_nettype none

module fkv_key_match (
   input  logic                 clock,
   input  logic                 reset,
   input  fkv_pkg::fkv_step_type step,
   input  logic [7:0]           data_byte,
   output logic [2:0]           hit_type   // 0 none, else message type of the key
);
   import fkv_pkg::*;

   logic [NUM_KEYS-1:0] cand_ff, cand_in;
   logic [3:0]          key_len_ff, key_len_in;
   logic [7:0]          upper;

   assign upper = to_upper(data_byte);

   always_comb begin
      cand_in    = cand_ff;
      key_len_in = key_len_ff;
      if (step.line_end) begin
         cand_in    = '1;
         key_len_in = 4'd0;
      end else if (step.key_en) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            if (cand_ff[i] && (key_len_ff >= key_len(3'(i)) ||
                               key_char(3'(i), key_len_ff[2:0]) != upper)) begin
               cand_in[i] = 1'b0;
            end
         end
         // saturates, such long keys match nothing anyway
         if (key_len_ff != 4'd15) begin
            key_len_in = key_len_ff + 4'd1;
         end
      end
   end

   // first surviving key whose length is complete
   always_comb begin
      hit_type = 3'd0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (cand_ff[i] && key_len_ff == key_len(3'(i))) begin
            hit_type = 3'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= '1;
         key_len_ff <= 4'd0;
      end else begin
         cand_ff    <= cand_in;
         key_len_ff <= key_len_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/fkv_value_parse.sv */
// value tracker: saturating signed decimal parse and the "true" match for ping
`timescale 1ns / 1ps
`default_nettype none

module fkv_value_parse #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fkv_pkg::fkv_step_type step,
   input  logic [7:0]           data_byte,
   output logic [31:0]          motor_value,
   output logic                 ping_true
);
   import fkv_pkg::*;

   localparam int ACC_W = VALUE_WIDTH;
   localparam int PRD_W = VALUE_WIDTH + 4;
   localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
   localparam logic [PRD_W-1:0] POS_MAX = {5'd0, {(VALUE_WIDTH-1){1'b1}}};

   logic [ACC_W-1:0] accum_ff, accum_in;
   logic             neg_ff, neg_in;
   logic             sat_ff, sat_in;
   num_phase_type    num_ff, num_in;
   true_match_type   true_ff, true_in;

   logic             is_digit, is_space;
   logic [3:0]       digit;
   logic [PRD_W-1:0] limit, prod;
   logic [7:0]       lower;
   logic [EXT_W-1:0] ext;

   assign lower = to_lower(data_byte);
   assign digit = 4'(data_byte - CHAR_ZERO);
   assign limit = POS_MAX + PRD_W'(neg_ff);
   // accum * 10 + digit, compared against the signed limit
   assign prod  = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0} + PRD_W'(digit);

   always_comb begin
      is_digit = data_byte inside {[8'h30:8'h39]};
      is_space = data_byte inside {8'd32, [8'd9:8'd13]};
   end

   always_comb begin
      accum_in = accum_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      num_in   = num_ff;
      true_in  = true_ff;
      if (step.line_end) begin
         accum_in = '0;
         neg_in   = 1'b0;
         sat_in   = 1'b0;
         num_in   = NUM_SPACE;
         true_in  = TRUE_0;
      end else if (step.value_en) begin
         case (true_ff)
            TRUE_0:  true_in = (lower == true_char(true_ff)) ? TRUE_1 : TRUE_MISS;
            TRUE_1:  true_in = (lower == true_char(true_ff)) ? TRUE_2 : TRUE_MISS;
            TRUE_2:  true_in = (lower == true_char(true_ff)) ? TRUE_3 : TRUE_MISS;
            TRUE_3:  true_in = (lower == true_char(true_ff)) ? TRUE_4 : TRUE_MISS;
            TRUE_4:  true_in = (data_byte == CHAR_CLOSE) ? TRUE_HIT : TRUE_MISS;
            default: true_in = TRUE_MISS;
         endcase

         if (num_ff == NUM_SPACE && !is_digit) begin
            if (is_space) begin
               num_in = NUM_SPACE;
            end else if (data_byte == CHAR_PLUS || data_byte == CHAR_MINUS) begin
               neg_in = (data_byte == CHAR_MINUS);
               num_in = NUM_SIGN;
            end else begin
               num_in = NUM_DONE;
            end
         end else if (num_ff != NUM_DONE) begin
            if (is_digit) begin
               num_in = NUM_DIGITS;
               if (!sat_ff) begin
                  if (prod > limit) begin
                     accum_in = limit[ACC_W-1:0];
                     sat_in   = 1'b1;
                  end else begin
                     accum_in = prod[ACC_W-1:0];
                  end
               end
            end else begin
               num_in = NUM_DONE;
            end
         end
      end
   end

   always_comb begin
      ext         = EXT_W'(accum_ff);
      motor_value = neg_ff ? 32'(-ext) : ext[31:0];
   end

   assign ping_true = (true_ff == TRUE_HIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff  <= 1'b0;
         sat_ff  <= 1'b0;
         num_ff  <= NUM_SPACE;
         true_ff <= TRUE_0;
      end else begin
         neg_ff  <= neg_in;
         sat_ff  <= sat_in;
         num_ff  <= num_in;
         true_ff <= true_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else begin
         accum_ff <= accum_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/fkv_line_ctrl.sv */
// line framing state machine and result selection at end of line
`timescale 1ns / 1ps
`default_nettype none

module fkv_line_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             data_byte,
   input  logic [2:0]             hit_type,
   input  logic                   ping_true,
   input  logic [31:0]            motor_value,
   output fkv_pkg::fkv_step_type  step,
   output fkv_pkg::fkv_result_type result
);
   import fkv_pkg::*;

   line_phase_type phase_ff, phase_in;
   logic           framed_ff, framed_in;
   logic           close_ff, close_in;
   logic           is_newline;

   assign is_newline = (data_byte == CHAR_NEWLINE);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      framed_in = framed_ff;
      close_in  = close_ff;
      if (advance) begin
         if (is_newline) begin
            phase_in  = LINE_START;
            framed_in = 1'b0;
            close_in  = 1'b0;
         end else begin
            close_in = (data_byte == CHAR_CLOSE);
            case (phase_ff)
               LINE_START: begin
                  framed_in = (data_byte == CHAR_OPEN);
                  phase_in  = LINE_KEY;
               end
               LINE_KEY: begin
                  if (data_byte == CHAR_COLON) begin
                     phase_in = LINE_VALUE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      step.line_end = advance && is_newline;
      step.key_en   = advance && !is_newline && phase_ff == LINE_KEY &&
                      data_byte != CHAR_COLON;
      step.value_en = advance && !is_newline && phase_ff == LINE_VALUE;

      result.msg_type    = MSG_ERROR;
      result.error_code  = ERR_NOT_FRAMED;
      result.ping_flag   = 1'b0;
      result.motor_value = 32'd0;
      if (phase_ff == LINE_START || !framed_ff || !close_ff) begin
         result.error_code = ERR_NOT_FRAMED;
      end else if (phase_ff != LINE_VALUE) begin
         result.error_code = ERR_NO_COLON;
      end else if (hit_type == MSG_ERROR) begin
         result.error_code = ERR_UNKNOWN_KEY;
      end else if (hit_type == MSG_PING) begin
         result.msg_type  = MSG_PING;
         result.ping_flag = ping_true;
      end else begin
         result.msg_type    = hit_type;
         result.motor_value = motor_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= LINE_START;
         framed_ff <= 1'b0;
         close_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         framed_ff <= framed_in;
         close_ff  <= close_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/framed_key_value_command_parser.sv */
// top level of the framed key/value command parser
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  beat contents
// req_      in         one received character per beat, newline ends the line
// rsp_      out        one result per line, kind in tuser, details in tdata
//
// one character per cycle while no newline waits: a beat lands in the input register,
// and the framing, key and value trackers update from it in the next cycle unless it waits
// a newline beat also loads the result register; it waits in the input register only
// while the result register is still full and not being taken, other beats never wait
// reset is synchronous, active high, and returns the parser to start of line
// rsp_tready low holds back only newline beats; characters keep flowing until a
// waiting newline fills the input register, then req_tready drops as well

module framed_key_value_command_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] error_code, [2] ping_flag, [34:3] motor_value
   output logic [2:0]  rsp_tuser    // [2:0] msg_type
);
   import fkv_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic           out_valid_ff, out_valid_in;
   fkv_result_type out_ff;

   logic           advance;
   logic           out_free;
   fkv_step_type   step;
   fkv_result_type result;
   logic [2:0]     hit_type;
   logic           ping_true;
   logic [31:0]    motor_value;

   assign out_free   = !out_valid_ff || rsp_tready;
   // a character that is not a newline never needs room in the result register
   assign advance    = in_valid_ff && (out_free || in_byte_ff != CHAR_NEWLINE);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = (out_valid_ff && !rsp_tready) || step.line_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step.line_end) begin
         out_ff <= result;
      end
   end

   fkv_line_ctrl u_line_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .hit_type    (hit_type),
      .ping_true   (ping_true),
      .motor_value (motor_value),
      .step        (step),
      .result      (result)
   );

   fkv_key_match u_key_match (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .hit_type  (hit_type)
   );

   fkv_value_parse #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_value_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .motor_value (motor_value),
      .ping_true   (ping_true)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.msg_type;
   assign rsp_tdata  = {5'd0, out_ff.motor_value, out_ff.ping_flag, out_ff.error_code};

endmodule

`default_nettype wire

/* verif/fkv_line_checker.sv */
// line-result predictor and comparator for the framed key/value command parser
`timescale 1ns / 1ps

module fkv_line_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [1:0] error_code, [2] ping_flag, [34:3] motor_value
   input  logic [2:0]  rsp_tuser,   // [2:0] msg_type
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import fkv_pkg::*;

   localparam logic [2:0]  MSG_MOTOR_0  = 3'd2;
   localparam int          PING_LEN     = 4;
   localparam int          MOTOR_LEN    = 7;
   localparam logic [63:0] POS_LIMIT    = 64'h7fff_ffff;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_RETURN  = 8'h0d;

   // predicted parser state for the line in progress
   line_phase_type cur_line;
   logic           framed;
   logic [5:0]     cands;
   logic [3:0]     key_seen;
   logic [63:0]    accum;
   logic           neg;
   num_phase_type  num_st;
   logic           sat;
   true_match_type tru;
   logic           prev_close;

   fkv_result_type line_outcomes[$];

   task automatic clear_line_state();
      cur_line   = LINE_START;
      framed     = 1'b0;
      cands      = '1;
      key_seen   = '0;
      accum      = '0;
      neg        = 1'b0;
      num_st     = NUM_SPACE;
      sat        = 1'b0;
      tru        = TRUE_0;
      prev_close = 1'b0;
   endtask

   // decimal accumulate with saturation at the signed 32-bit magnitude
   task automatic push_digit(input logic [7:0] d);
      logic [63:0] lim;
      lim = POS_LIMIT + {63'd0, neg};
      if (!sat) begin
         if (accum > (lim - {56'd0, d}) / 10) begin
            accum = lim;
            sat   = 1'b1;
         end else begin
            accum = accum * 10 + {56'd0, d};
         end
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      fkv_result_type r;
      int             hit;
      string          name;
      string          word;
      logic [7:0]     up;
      logic [7:0]     lo;
      logic           is_digit;
      logic           is_space;
      word = "true";
      if (c == CHAR_NEWLINE) begin
         r   = '0;
         hit = -1;
         if (cur_line == LINE_START || !framed || !prev_close) begin
            r.error_code = ERR_NOT_FRAMED;
         end else if (cur_line != LINE_VALUE) begin
            r.error_code = ERR_NO_COLON;
         end else begin
            for (int k = 0; k < NUM_KEYS; k++)
               if (hit < 0 && cands[k] && key_seen == ((k == KEY_PING) ? PING_LEN : MOTOR_LEN))
                  hit = k;
            if (hit < 0) begin
               r.error_code = ERR_UNKNOWN_KEY;
            end else if (hit == KEY_PING) begin
               r.msg_type  = MSG_PING;
               r.ping_flag = (tru == TRUE_HIT);
            end else begin
               r.msg_type    = MSG_MOTOR_0 + 3'(hit - 1);
               r.motor_value = neg ? 32'(64'd0 - accum) : accum[31:0];
            end
         end
         line_outcomes.push_back(r);
         clear_line_state();
      end else begin
         if (cur_line == LINE_START) begin
            framed   = (c == CHAR_OPEN);
            cur_line = LINE_KEY;
         end else if (cur_line == LINE_KEY) begin
            if (c == CHAR_COLON) begin
               cur_line = LINE_VALUE;
            end else begin
               up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
               for (int k = 0; k < NUM_KEYS; k++) begin
                  if (k == KEY_PING) name = "PING";
                  else name = $sformatf("MOTOR_%0d", k - 1);
                  if (cands[k] && (key_seen >= name.len() || name[key_seen] != up))
                     cands[k] = 1'b0;
               end
               if (key_seen != 4'd15) key_seen = key_seen + 4'd1;
            end
         end else begin
            lo       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            is_digit = (c >= "0" && c <= "9");
            is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_RETURN);
            // "true" followed directly by the closing bracket
            if (tru < TRUE_4)
               tru = (lo == word[int'(tru)]) ? true_match_type'(tru + 3'd1) : TRUE_MISS;
            else if (tru == TRUE_4)
               tru = (c == CHAR_CLOSE) ? TRUE_HIT : TRUE_MISS;
            else
               tru = TRUE_MISS;
            case (num_st)
               NUM_SPACE: begin
                  if (!is_space) begin
                     if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        neg    = (c == CHAR_MINUS);
                        num_st = NUM_SIGN;
                     end else if (is_digit) begin
                        push_digit(c - CHAR_ZERO);
                        num_st = NUM_DIGITS;
                     end else begin
                        num_st = NUM_DONE;
                     end
                  end
               end
               NUM_SIGN, NUM_DIGITS: begin
                  if (is_digit) begin
                     push_digit(c - CHAR_ZERO);
                     num_st = NUM_DIGITS;
                  end else begin
                     num_st = NUM_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
         prev_close = (c == CHAR_CLOSE);
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      $display("%0t ns: %s mismatch on result %0d, expected %0h, got %0h",
               $time, field, checked, want, got);
   endtask

   always @(posedge clock) begin : watch
      fkv_result_type got;
      fkv_result_type want;
      if (reset) begin
         clear_line_state();
         line_outcomes.delete();
      end else begin
         if (req_tvalid && req_tready) take_char(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.msg_type    = rsp_tuser;
            got.error_code  = rsp_tdata[1:0];
            got.ping_flag   = rsp_tdata[2];
            got.motor_value = rsp_tdata[34:3];
            if (line_outcomes.size() == 0) begin
               fail_count++;
               $display("%0t ns: result with no line pending, expected none, got type %0d",
                        $time, got.msg_type);
            end else begin
               want = line_outcomes.pop_front();
               checked++;
               if (got.msg_type !== want.msg_type)
                  flag_mismatch("msg_type", want.msg_type, got.msg_type);
               if (got.error_code !== want.error_code)
                  flag_mismatch("error_code", want.error_code, got.error_code);
               if (got.ping_flag !== want.ping_flag)
                  flag_mismatch("ping_flag", want.ping_flag, got.ping_flag);
               if (got.motor_value !== want.motor_value)
                  flag_mismatch("motor_value", want.motor_value, got.motor_value);
            end
         end
      end
      pending = line_outcomes.size();
   end

endmodule

/* verif/testbench.sv */
// stimulus and verdict for the framed key/value command parser
`timescale 1ns / 1ps

module testbench;
   import fkv_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_BYTES   = 1500;
   localparam int LONG_HOLD      = 400;     // receiver hold-off, in cycles
   localparam int DRAIN_LIMIT    = 5000;    // cycles allowed for results to drain
   localparam int TAIL_CYCLES    = 20;      // settle time after the last result
   localparam int TIMEOUT_CYCLES = 400000;

   typedef logic [7:0] char_queue_type[$];

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [1:0] error_code, [2] ping_flag, [34:3] motor_value
   logic [2:0]  rsp_tuser;    // [2:0] msg_type

   int  fail_count;
   int  pending;
   int  checked;
   int  send_idle_pct;        // chance in a hundred that the sender skips a cycle
   int  recv_stall_pct;       // chance in a hundred that the receiver stalls a cycle
   bit  hold_off_req;         // asks the receiver for one long hold-off
   int  bytes_sent;
   int  lines_sent;
   char_queue_type line_buf;  // characters of the line being built, newline excluded

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   framed_key_value_command_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fkv_line_checker line_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // one character beat: random idle cycles first, then hold valid until taken
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // the buffered line followed by its newline beat
   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
      send_char(CHAR_NEWLINE);
      lines_sent++;
   endtask

   task automatic add_char(input logic [7:0] c);
      line_buf.push_back(c);
   endtask

   // append text; with mix_case set each lower-case letter may turn upper case
   task automatic add_text(input string s, input bit mix_case);
      logic [7:0] b;
      for (int i = 0; i < s.len(); i++) begin
         b = s[i];
         if (mix_case && b >= "a" && b <= "z" && $urandom_range(1) == 1) b = b - 8'd32;
         add_char(b);
      end
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      add_text(s, 1'b0);
      send_line();
   endtask

   // stop offering beats and wait until every predicted result has come back or the drain limit runs out
   task automatic drain_results();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      @(posedge clock);
   endtask

   // mostly well-formed commands with random content, the rest noise
   task automatic build_random_line();
      int         k;
      int         r;
      logic [7:0] b;
      line_buf.delete();
      if ($urandom_range(99) >= 75) begin
         // noise: arbitrary bytes, sometimes inside brackets
         if ($urandom_range(1) == 1) add_char(CHAR_OPEN);
         repeat ($urandom_range(14)) begin
            do b = 8'($urandom_range(255)); while (b == CHAR_NEWLINE);
            add_char(b);
         end
         if ($urandom_range(1) == 1) add_char(CHAR_CLOSE);
      end else begin
         k = $urandom_range(NUM_KEYS - 1);
         add_char(CHAR_OPEN);
         case ($urandom_range(11))
            0:       add_text("motor_5", 1'b1);
            1:       add_text("pingmotor_1", 1'b1);
            2:       add_text("motor_", 1'b1);
            3:       add_text("pin", 1'b1);
            default: begin
               if (k == KEY_PING) add_text("ping", 1'b1);
               else add_text($sformatf("motor_%0d", k - 1), 1'b1);
            end
         endcase
         if ($urandom_range(15) != 0) add_char(CHAR_COLON);
         if (k == KEY_PING) begin
            case ($urandom_range(7))
               4:       add_text("tru", 1'b1);
               5:       add_text("truee", 1'b1);
               6:       add_text("false", 1'b1);
               7:       add_text(" true", 1'b1);
               default: add_text("true", 1'b1);
            endcase
         end else begin
            // optional whitespace: space, tab, vertical tab, form feed, return
            if ($urandom_range(7) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  case ($urandom_range(4))
                     0:       b = 8'h20;
                     1:       b = 8'h09;
                     2:       b = 8'h0b;
                     3:       b = 8'h0c;
                     default: b = 8'h0d;
                  endcase
                  add_char(b);
               end
            end
            case ($urandom_range(3))
               0:       add_char(CHAR_PLUS);
               1:       add_char(CHAR_MINUS);
               default: begin
               end
            endcase
            r = $urandom_range(9);
            if (r == 0) begin
               // values around the saturation point
               case ($urandom_range(4))
                  0:       add_text("2147483647", 1'b0);
                  1:       add_text("2147483648", 1'b0);
                  2:       add_text("2147483649", 1'b0);
                  3:       add_text("99999999999", 1'b0);
                  default: add_text("0002147483646", 1'b0);
               endcase
            end else if (r < 9) begin
               repeat ($urandom_range(1, (r < 3) ? 12 : 4))
                  add_char(CHAR_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(7) == 0) add_char(8'($urandom_range(32, 126)));
         end
         if ($urandom_range(15) != 0) add_char(CHAR_CLOSE);
      end
   endtask

   // receiver: random stalls, or one long hold-off when asked
   initial begin : receiver
      int held;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // safety net against a hung handshake
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("%0t ns: run timed out with %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int random_start;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b0;
      bytes_sent     = 0;
      lines_sent     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // framing: empty line, lone open bracket, bad start, missing close
      send_text("");
      send_text("<");
      send_text("x>");
      send_text("<PING:true");
      // ping flag and its case folding
      send_text("<PING:true>");
      send_text("<ping:TrUe>");
      send_text("<PING:truex>");
      send_text("<PING:>");
      send_text("<PING:tr:ue>");
      // missing colon and unknown keys, long key saturating its length
      send_text("<PING>");
      send_text("<>");
      send_text("<:>");
      send_text("<MOTOR_5:1>");
      send_text("<PINGX:true>");
      send_text("<MOTOR_0000000000000000:1>");
      // motor values: plain, signed, trailing junk, saturation both ways
      send_text("<MOTOR_0:123>");
      send_text("<motor_1:-45>");
      send_text("<Motor_2:+7x>");
      send_text("<MOTOR_3:2147483647>");
      send_text("<MOTOR_3:2147483648>");
      send_text("<MOTOR_4:-2147483648>");
      send_text("<MOTOR_4:-99999999999>");
      send_text("<MOTOR_1:9999999999999999999999999999999999>");
      send_text("<MOTOR_0:->");
      send_text("<MOTOR_1:a:b>");
      // leading whitespace: tab, vertical tab, form feed, return, space
      line_buf.delete();
      add_text("<MOTOR_2:", 1'b0);
      add_char(8'h09);
      add_char(8'h0b);
      add_char(8'h0c);
      add_char(8'h0d);
      add_text(" 12>", 1'b0);
      send_line();
      // extreme byte values inside a frame
      line_buf.delete();
      add_char(CHAR_OPEN);
      add_char(8'hff);
      add_char(CHAR_COLON);
      add_char(8'h00);
      add_char(CHAR_CLOSE);
      send_line();
      drain_results();

      // random part in four pacing phases
      random_start = bytes_sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               // no idling, but one long receiver hold to back the parser up
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_off_req   = 1'b1;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 0;
            end
            2: begin
               // sender pauses until every result is home
               drain_results();
               send_idle_pct  = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase
         while (bytes_sent - random_start < (ph + 1) * RANDOM_BYTES / 4) begin
            build_random_line();
            send_line();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d character beats in %0d lines, %0d line results compared",
               bytes_sent, lines_sent, checked);
      $display("pacing: free flow, sender gaps, receiver stalls, both, one long hold, one drain");
      if (pending != 0)
         $display("%0d expected results never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
